// ===== sv/tsm_pkg.sv =====
// Types, phase codes and fixed pin actions for the two-wire sensor master.
// No dependencies; imported by tsm_seq, the top level and the testbench.
`default_nettype none
package tsm_pkg;

   localparam int CODE_BITS  = 8;
   localparam int VALUE_BITS = 16;
   localparam int SETTLE_BITS = 8;
   localparam int CONV_BITS  = 16;
   localparam int CSR_DATA_BITS = 16;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic CSR_BIT_SETTLE  = 1'b0;
   localparam logic CSR_CONV_DELAY  = 1'b1;

   localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = 8'd1;
   localparam logic [CONV_BITS-1:0]   CONV_RESET   = 16'd200;

   typedef enum logic [4:0] {
      PH_IDLE, PH_TS0, PH_TS1, PH_TS2, PH_TS3, PH_TS4, PH_TS5, PH_TS6,
      PH_TX_DATA, PH_TX_HI, PH_TX_LO,
      PH_ACK_HI, PH_ACK_LOW, PH_ACK_WAIT, PH_CONV, PH_POLL,
      PH_RD_HI, PH_RD_SETTLE,
      PH_MA0, PH_MA1, PH_MA2, PH_MA3,
      PH_CRC0, PH_CRC1, PH_CRC2
   } phase_type;

   typedef struct packed {
      logic clk;
      logic en;
      logic dat;
   } pins_type;

   typedef struct packed {
      logic                  cmd;
      logic [CODE_BITS-1:0]  command_code;
      logic                  data_line;
   } req_type;

   typedef struct packed {
      pins_type               pins;
      logic                   busy_res;
      logic                   result_valid;
      logic [VALUE_BITS-1:0]  measured_value;
      logic                   ack_low_error;
      logic                   ack_release_error;
   } rsp_type;

   // pin pattern of the fixed-sequence phases (start, master ack, checksum skip)
   function automatic pins_type fixed_pins(input phase_type ph);
      pins_type p;
      p = '{clk: 1'b0, en: 1'b0, dat: 1'b0};
      case (ph)
         PH_TS0:  p = '{clk: 1'b0, en: 1'b1, dat: 1'b1};
         PH_TS1:  p = '{clk: 1'b1, en: 1'b1, dat: 1'b1};
         PH_TS2:  p = '{clk: 1'b1, en: 1'b1, dat: 1'b0};
         PH_TS3:  p = '{clk: 1'b0, en: 1'b1, dat: 1'b0};
         PH_TS4:  p = '{clk: 1'b1, en: 1'b1, dat: 1'b0};
         PH_TS5:  p = '{clk: 1'b1, en: 1'b1, dat: 1'b1};
         PH_TS6:  p = '{clk: 1'b0, en: 1'b1, dat: 1'b1};
         PH_MA0:  p = '{clk: 1'b0, en: 1'b1, dat: 1'b1};
         PH_MA1:  p = '{clk: 1'b0, en: 1'b1, dat: 1'b0};
         PH_MA2:  p = '{clk: 1'b1, en: 1'b1, dat: 1'b0};
         PH_MA3:  p = '{clk: 1'b0, en: 1'b0, dat: 1'b0};
         PH_CRC0: p = '{clk: 1'b0, en: 1'b1, dat: 1'b1};
         PH_CRC1: p = '{clk: 1'b1, en: 1'b1, dat: 1'b1};
         PH_CRC2: p = '{clk: 1'b0, en: 1'b1, dat: 1'b1};
         default: p = '{clk: 1'b0, en: 1'b0, dat: 1'b0};
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

// ===== sv/tsm_fifo.sv =====
// Small word queue with registered pointers and a fill count.
// No package dependencies; used for the command queue and the result queue.
`default_nettype none
module tsm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

// ===== sv/tsm_seq.sv =====
// Pin sequencer: runs one start or tick word per enabled cycle, holds config.
// Depends on tsm_pkg.
`default_nettype none
module tsm_seq #(
   parameter int RESULT_BITS = 16,
   parameter int DELAY_BITS  = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic                                csr_index,
   input  wire logic [tsm_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire logic                                go,
   input  wire tsm_pkg::req_type                    req,
   output tsm_pkg::rsp_type                         rsp
);
   import tsm_pkg::*;

   localparam int CNT_W = $clog2(RESULT_BITS + 1);
   localparam logic [CNT_W-1:0] RES_COUNT = CNT_W'(RESULT_BITS);
   localparam logic [CNT_W-1:0] CMD_COUNT = CNT_W'(8);

   logic [SETTLE_BITS-1:0] settle_ff;
   logic [CONV_BITS-1:0]   conv_ff;

   phase_type               phase_ff, phase_in;
   logic [CNT_W-1:0]        bit_count_ff, bit_count_in, bit_count_inc;
   logic [DELAY_BITS-1:0]   delay_ff, delay_in;
   logic [CODE_BITS-1:0]    command_ff, command_in;
   logic [RESULT_BITS-1:0]  read_ff, read_in;
   logic [1:0]              ack_ff, ack_in;
   pins_type                pins_ff, pins_in;
   logic                    done;
   logic                    tick, delay_zero;

   assign tick          = (req.cmd == CMD_TICK);
   assign delay_zero    = (delay_ff == '0);
   assign bit_count_inc = bit_count_ff + 1'b1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (!tick) begin
         if (phase_ff == PH_IDLE) begin
            phase_in = PH_TS0;
         end
      end else begin
         case (phase_ff)
            PH_IDLE:      phase_in = PH_IDLE;
            PH_TS6:       phase_in = PH_TX_DATA;
            PH_TX_DATA:   phase_in = PH_TX_HI;
            PH_TX_HI:     phase_in = PH_TX_LO;
            PH_TX_LO:     phase_in = (bit_count_inc >= CMD_COUNT) ? PH_ACK_HI : PH_TX_DATA;
            PH_ACK_HI:    phase_in = PH_ACK_LOW;
            PH_ACK_LOW:   phase_in = PH_ACK_WAIT;
            PH_ACK_WAIT:  phase_in = delay_zero ? PH_CONV : PH_ACK_WAIT;
            PH_CONV:      phase_in = delay_zero ? PH_POLL : PH_CONV;
            PH_POLL:      phase_in = req.data_line ? PH_POLL : PH_RD_HI;
            PH_RD_HI:     phase_in = PH_RD_SETTLE;
            PH_RD_SETTLE: begin
               if (!delay_zero) begin
                  phase_in = PH_RD_SETTLE;
               end else if (bit_count_inc >= RES_COUNT) begin
                  phase_in = PH_CRC0;
               end else if (bit_count_inc[2:0] == 3'd0) begin
                  phase_in = PH_MA0;
               end else begin
                  phase_in = PH_RD_HI;
               end
            end
            PH_MA3:       phase_in = PH_RD_HI;
            PH_CRC2:      phase_in = PH_IDLE;
            default:      phase_in = phase_type'(phase_ff + 5'd1);
         endcase
      end
   end

   // datapath and pins
   always_comb begin
      bit_count_in = bit_count_ff;
      delay_in     = delay_ff;
      command_in   = command_ff;
      read_in      = read_ff;
      ack_in       = ack_ff;
      pins_in      = pins_ff;
      done         = 1'b0;
      if (!tick) begin
         if (phase_ff == PH_IDLE) begin
            command_in   = req.command_code;
            ack_in       = '0;
            bit_count_in = '0;
            read_in      = '0;
            delay_in     = '0;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: ;
            PH_TS0, PH_TS1, PH_TS2, PH_TS3, PH_TS4, PH_TS5: begin
               pins_in = fixed_pins(phase_ff);
            end
            PH_TS6: begin
               pins_in      = fixed_pins(phase_ff);
               bit_count_in = '0;
            end
            PH_TX_DATA: begin
               pins_in = '{clk: 1'b0, en: 1'b1,
                           dat: command_ff[3'd7 - bit_count_ff[2:0]]};
            end
            PH_TX_HI: pins_in.clk = 1'b1;
            PH_TX_LO: begin
               pins_in.clk  = 1'b0;
               bit_count_in = bit_count_inc;
            end
            PH_ACK_HI: pins_in = '{clk: 1'b1, en: 1'b0, dat: 1'b0};
            PH_ACK_LOW: begin
               if (req.data_line) begin
                  ack_in[0] = 1'b1;
               end
               pins_in.clk = 1'b0;
               delay_in    = DELAY_BITS'(settle_ff);
            end
            PH_ACK_WAIT: begin
               if (!delay_zero) begin
                  delay_in = delay_ff - 1'b1;
               end else begin
                  if (!req.data_line) begin
                     ack_in[1] = 1'b1;
                  end
                  delay_in = DELAY_BITS'(conv_ff);
               end
            end
            PH_CONV: begin
               if (!delay_zero) begin
                  delay_in = delay_ff - 1'b1;
               end
            end
            PH_POLL: begin
               if (!req.data_line) begin
                  bit_count_in = '0;
                  read_in      = '0;
               end
            end
            PH_RD_HI: begin
               pins_in  = '{clk: 1'b1, en: 1'b0, dat: 1'b0};
               delay_in = DELAY_BITS'(settle_ff);
            end
            PH_RD_SETTLE: begin
               if (!delay_zero) begin
                  delay_in = delay_ff - 1'b1;
               end else begin
                  read_in      = {read_ff[RESULT_BITS-2:0], req.data_line};
                  pins_in.clk  = 1'b0;
                  bit_count_in = bit_count_inc;
               end
            end
            PH_MA0, PH_MA1, PH_MA2, PH_MA3, PH_CRC0, PH_CRC1: begin
               pins_in = fixed_pins(phase_ff);
            end
            PH_CRC2: begin
               pins_in = fixed_pins(phase_ff);
               done    = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp.pins              = pins_in;
      rsp.busy_res          = (phase_in != PH_IDLE);
      rsp.result_valid      = done;
      rsp.measured_value    = done ? VALUE_BITS'(read_in) : '0;
      rsp.ack_low_error     = ack_in[0];
      rsp.ack_release_error = ack_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_RESET;
         conv_ff   <= CONV_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_BIT_SETTLE) begin
            settle_ff <= csr_wdata[SETTLE_BITS-1:0];
         end else begin
            conv_ff <= csr_wdata[CONV_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= '0;
         delay_ff     <= '0;
         command_ff   <= '0;
         read_ff      <= '0;
         ack_ff       <= '0;
         pins_ff      <= '{clk: 1'b0, en: 1'b0, dat: 1'b0};
      end else if (go) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         delay_ff     <= delay_in;
         command_ff   <= command_in;
         read_ff      <= read_in;
         ack_ff       <= ack_in;
         pins_ff      <= pins_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/two_wire_sensor_measure_master_unit.sv =====
// Top level of the two-wire sensor measurement master: command queue,
// pin sequencer and result queue. Depends on tsm_pkg, tsm_fifo, tsm_seq.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------------
//   request  | push / full      | req_cmd, req_command_code, req_data_line
//   response | empty / pop      | rsp_clock_level ... rsp_ack_release_error
//   csr      | csr_write_en     | csr_index, csr_wdata
//
// One word per cycle sustained while the result queue has room; a queued word passes
// through the combinational pin sequencer step into the result queue.
// Synchronous reset empties both queues, idles the sequencer, restores csr.
// Both queues are two words deep; a stalled response side fills the result
// queue and then the command queue before full rises.
`default_nettype none
module two_wire_sensor_measure_master_unit #(
   parameter int RESULT_BITS = 16,
   parameter int DELAY_BITS  = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   output logic                                    full,
   input  wire logic                               req_cmd,
   input  wire logic [tsm_pkg::CODE_BITS-1:0]      req_command_code,
   input  wire logic                               req_data_line,
   output logic                                    empty,
   input  wire logic                               pop,
   output logic                                    rsp_clock_level,
   output logic                                    rsp_data_drive_enable,
   output logic                                    rsp_data_level,
   output logic                                    rsp_busy_res,
   output logic                                    rsp_result_valid,
   output logic [tsm_pkg::VALUE_BITS-1:0]          rsp_measured_value,
   output logic                                    rsp_ack_low_error,
   output logic                                    rsp_ack_release_error,
   input  wire logic                               csr_write_en,
   input  wire logic                               csr_index,
   input  wire logic [tsm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import tsm_pkg::*;

   req_type in_word, mid_word;
   rsp_type seq_word, out_word;
   logic    mid_empty, mid_full_unused, rsp_full, go;

   assign in_word = '{cmd: req_cmd, command_code: req_command_code,
                      data_line: req_data_line};
   assign go = !mid_empty && !rsp_full;

   tsm_fifo #(.WIDTH($bits(req_type)), .DEPTH(2)) u_req_q (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (in_word),
      .full  (full),
      .pop   (go),
      .rdata (mid_word),
      .empty (mid_empty)
   );

   tsm_seq #(.RESULT_BITS(RESULT_BITS), .DELAY_BITS(DELAY_BITS)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .go           (go),
      .req          (mid_word),
      .rsp          (seq_word)
   );

   tsm_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (go),
      .wdata (seq_word),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (out_word),
      .empty (empty)
   );

   assign mid_full_unused       = 1'b0;
   assign rsp_clock_level       = out_word.pins.clk;
   assign rsp_data_drive_enable = out_word.pins.en;
   assign rsp_data_level        = out_word.pins.dat;
   assign rsp_busy_res          = out_word.busy_res;
   assign rsp_result_valid      = out_word.result_valid;
   assign rsp_measured_value    = out_word.measured_value;
   assign rsp_ack_low_error     = out_word.ack_low_error;
   assign rsp_ack_release_error = out_word.ack_release_error | mid_full_unused;
endmodule
`default_nettype wire

// ===== tb/sv/two_wire_sensor_measure_master_unit_tb.sv =====
// Self-checking testbench for two_wire_sensor_measure_master_unit: a directed table,
// then randomized sensor transactions under several timing settings, checked word by word.
// Depends on tsm_pkg and the RTL of the block only.
module two_wire_sensor_measure_master_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsm_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     push;
   logic                     full;
   logic                     req_cmd;
   logic [CODE_BITS-1:0]     req_command_code;
   logic                     req_data_line;
   logic                     empty;
   logic                     pop;
   logic                     rsp_clock_level;
   logic                     rsp_data_drive_enable;
   logic                     rsp_data_level;
   logic                     rsp_busy_res;
   logic                     rsp_result_valid;
   logic [VALUE_BITS-1:0]    rsp_measured_value;
   logic                     rsp_ack_low_error;
   logic                     rsp_ack_release_error;
   logic                     csr_write_en;
   logic                     csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   two_wire_sensor_measure_master_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_cmd               (req_cmd),
      .req_command_code      (req_command_code),
      .req_data_line         (req_data_line),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_clock_level       (rsp_clock_level),
      .rsp_data_drive_enable (rsp_data_drive_enable),
      .rsp_data_level        (rsp_data_level),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_result_valid      (rsp_result_valid),
      .rsp_measured_value    (rsp_measured_value),
      .rsp_ack_low_error     (rsp_ack_low_error),
      .rsp_ack_release_error (rsp_ack_release_error),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   typedef struct packed {
      logic                 cmd;
      logic [CODE_BITS-1:0] code;
      logic                 line;
      logic [7:0]           count;
      logic                 typed;
      rsp_type              want;
   } stim_row_type;

   // sequencer copy kept by the testbench
   phase_type                seq_phase;
   logic [4:0]               seq_bits;
   logic [CONV_BITS-1:0]     seq_wait;
   logic [CODE_BITS-1:0]     seq_command;
   logic [VALUE_BITS-1:0]    seq_reading;
   logic                     seq_low_flag;
   logic                     seq_release_flag;
   logic [2:0]               seq_pins;
   logic [SETTLE_BITS-1:0]   settle_cfg;
   logic [CONV_BITS-1:0]     conv_cfg;

   rsp_type expected_pin_words[$];
   int      mismatches;
   int      words_checked;
   bit      idling_on;
   bit      paused_once;
   bit      hold_done;

   // settle 0, conversion 0 throughout
   stim_row_type directed_rows [0:26] = '{
      '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b1, '{3'b000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0}},
      '{CMD_TICK,  8'hFF, 1'b1, 8'd1,  1'b1, '{3'b000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0}},
      '{CMD_START, 8'hFF, 1'b0, 8'd1,  1'b1, '{3'b000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}},
      '{CMD_START, 8'h00, 1'b1, 8'd1,  1'b1, '{3'b000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}},
      '{CMD_TICK,  8'h00, 1'b1, 8'd7,  1'b0, '0},
      '{CMD_TICK,  8'hFF, 1'b0, 8'd24, 1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b1, 8'd1,  1'b1, '{3'b000, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b0}},
      '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b1, '{3'b000, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b1}},
      '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b1, 8'd6,  1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b0, '0},
      '{CMD_TICK,  8'hFF, 1'b1, 8'd36, 1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b0, 8'd2,  1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b1, '{3'b011, 1'b0, 1'b1, 16'hFFFF, 1'b1, 1'b1}},
      '{CMD_TICK,  8'h00, 1'b1, 8'd1,  1'b1, '{3'b011, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b1}},
      '{CMD_START, 8'h00, 1'b0, 8'd1,  1'b1, '{3'b011, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}},
      '{CMD_TICK,  8'h00, 1'b0, 8'd7,  1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b1, 8'd24, 1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b1, 8'd1,  1'b1, '{3'b000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}},
      '{CMD_TICK,  8'h00, 1'b1, 8'd1,  1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b0, 8'd36, 1'b0, '0},
      '{CMD_TICK,  8'hFF, 1'b1, 8'd2,  1'b0, '0},
      '{CMD_TICK,  8'h00, 1'b1, 8'd1,  1'b1, '{3'b011, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0}}
   };

   // {clock, drive enable, data} of the fixed-pattern phases
   function automatic logic [2:0] pattern_pins(input phase_type p);
      case (p)
         PH_TS0, PH_TS6, PH_MA0, PH_CRC0, PH_CRC2: return 3'b011;
         PH_TS1, PH_TS5, PH_CRC1:                  return 3'b111;
         PH_TS2, PH_TS4, PH_MA2:                   return 3'b110;
         PH_TS3, PH_MA1:                           return 3'b010;
         default:                                  return 3'b000;
      endcase
   endfunction

   function automatic rsp_type advance_sequencer(input logic cmd, input logic [7:0] code,
                                                 input logic line);
      rsp_type w;
      logic    done;
      done = 1'b0;
      if (cmd == CMD_START) begin
         if (seq_phase == PH_IDLE) begin
            seq_command      = code;
            seq_low_flag     = 1'b0;
            seq_release_flag = 1'b0;
            seq_bits         = '0;
            seq_reading      = '0;
            seq_wait         = '0;
            seq_phase        = PH_TS0;
         end
      end else begin
         case (seq_phase)
            PH_IDLE: ;
            PH_TS0, PH_TS1, PH_TS2, PH_TS3, PH_TS4, PH_TS5, PH_TS6: begin
               seq_pins = pattern_pins(seq_phase);
               if (seq_phase == PH_TS6) begin
                  seq_bits  = '0;
                  seq_phase = PH_TX_DATA;
               end else
                  seq_phase = phase_type'(seq_phase + 1);
            end
            PH_TX_DATA: begin
               seq_pins  = {1'b0, 1'b1, seq_command[3'd7 - seq_bits[2:0]]};
               seq_phase = PH_TX_HI;
            end
            PH_TX_HI: begin
               seq_pins[2] = 1'b1;
               seq_phase   = PH_TX_LO;
            end
            PH_TX_LO: begin
               seq_pins[2] = 1'b0;
               seq_bits    = seq_bits + 1'b1;
               seq_phase   = (seq_bits >= 5'd8) ? PH_ACK_HI : PH_TX_DATA;
            end
            PH_ACK_HI: begin
               seq_pins  = 3'b100;
               seq_phase = PH_ACK_LOW;
            end
            PH_ACK_LOW: begin
               if (line) seq_low_flag = 1'b1;
               seq_pins[2] = 1'b0;
               seq_wait    = {8'h00, settle_cfg};
               seq_phase   = PH_ACK_WAIT;
            end
            PH_ACK_WAIT: begin
               if (seq_wait != 0)
                  seq_wait = seq_wait - 1'b1;
               else begin
                  if (!line) seq_release_flag = 1'b1;
                  seq_wait  = conv_cfg;
                  seq_phase = PH_CONV;
               end
            end
            PH_CONV: begin
               if (seq_wait != 0)
                  seq_wait = seq_wait - 1'b1;
               else
                  seq_phase = PH_POLL;
            end
            PH_POLL: begin
               if (!line) begin
                  seq_bits    = '0;
                  seq_reading = '0;
                  seq_phase   = PH_RD_HI;
               end
            end
            PH_RD_HI: begin
               seq_pins  = 3'b100;
               seq_wait  = {8'h00, settle_cfg};
               seq_phase = PH_RD_SETTLE;
            end
            PH_RD_SETTLE: begin
               if (seq_wait != 0)
                  seq_wait = seq_wait - 1'b1;
               else begin
                  seq_reading = {seq_reading[VALUE_BITS-2:0], line};
                  seq_pins[2] = 1'b0;
                  seq_bits    = seq_bits + 1'b1;
                  if (seq_bits >= 5'd16)
                     seq_phase = PH_CRC0;
                  else if (seq_bits[2:0] == 3'd0)
                     seq_phase = PH_MA0;
                  else
                     seq_phase = PH_RD_HI;
               end
            end
            PH_MA0, PH_MA1, PH_MA2, PH_MA3: begin
               seq_pins  = pattern_pins(seq_phase);
               seq_phase = (seq_phase == PH_MA3) ? PH_RD_HI : phase_type'(seq_phase + 1);
            end
            PH_CRC0, PH_CRC1, PH_CRC2: begin
               seq_pins = pattern_pins(seq_phase);
               if (seq_phase == PH_CRC2) begin
                  done      = 1'b1;
                  seq_phase = PH_IDLE;
               end else
                  seq_phase = phase_type'(seq_phase + 1);
            end
            default: ;
         endcase
      end
      w.pins              = pins_type'(seq_pins);
      w.busy_res          = (seq_phase != PH_IDLE);
      w.result_valid      = done;
      w.measured_value    = done ? seq_reading : '0;
      w.ack_low_error     = seq_low_flag;
      w.ack_release_error = seq_release_flag;
      return w;
   endfunction

   // what a plausible sensor puts on the data wire, mostly well-behaved
   function automatic logic sensor_line();
      case (seq_phase)
         PH_ACK_LOW:  return ($urandom_range(7) == 0);
         PH_ACK_WAIT: return (seq_wait != 0) ? 1'($urandom) : ($urandom_range(7) != 0);
         PH_POLL:     return ($urandom_range(3) != 0);
         default:     return 1'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_code();
      case ($urandom_range(4))
         0:       return 8'h03;
         1:       return 8'h05;
         2:       return 8'h00;
         3:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch at word %0d, %s: got %h, want %h", words_checked, field, got, want);
   endtask

   task automatic check_word(input rsp_type got, input rsp_type want);
      if (got.pins.clk !== want.pins.clk)
         report_mismatch("clock_level", 16'(got.pins.clk), 16'(want.pins.clk));
      if (got.pins.en !== want.pins.en)
         report_mismatch("data_drive_enable", 16'(got.pins.en), 16'(want.pins.en));
      if (got.pins.dat !== want.pins.dat)
         report_mismatch("data_level", 16'(got.pins.dat), 16'(want.pins.dat));
      if (got.busy_res !== want.busy_res)
         report_mismatch("busy_res", 16'(got.busy_res), 16'(want.busy_res));
      if (got.result_valid !== want.result_valid)
         report_mismatch("result_valid", 16'(got.result_valid), 16'(want.result_valid));
      if (got.measured_value !== want.measured_value)
         report_mismatch("measured_value", got.measured_value, want.measured_value);
      if (got.ack_low_error !== want.ack_low_error)
         report_mismatch("ack_low_error", 16'(got.ack_low_error), 16'(want.ack_low_error));
      if (got.ack_release_error !== want.ack_release_error)
         report_mismatch("ack_release_error", 16'(got.ack_release_error),
                         16'(want.ack_release_error));
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer_word(input logic cmd, input logic [7:0] code, input logic line,
                             input logic typed, input rsp_type want);
      rsp_type predicted;
      if (idling_on && $urandom_range(9) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      push             <= 1'b1;
      req_cmd          <= cmd;
      req_command_code <= code;
      req_data_line    <= line;
      @(posedge clock);
      while (full) @(posedge clock);
      predicted = advance_sequencer(cmd, code, line);
      expected_pin_words.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic hold_requests_until_drained();
      push <= 1'b0;
      while (expected_pin_words.size() != 0) @(negedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] settle, input logic [15:0] conv);
      hold_requests_until_drained();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_BIT_SETTLE;
      csr_wdata    <= {8'h00, settle};
      @(negedge clock);
      csr_index    <= CSR_CONV_DELAY;
      csr_wdata    <= conv;
      @(negedge clock);
      csr_write_en <= 1'b0;
      settle_cfg = settle;
      conv_cfg   = conv;
   endtask

   // whole transactions until the budget of counted start and tick words is used, ending idle
   task automatic run_measurements(input int budget);
      int counted;
      counted = 0;
      do begin
         repeat ($urandom_range(0, 3))
            offer_word(CMD_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
         offer_word(CMD_START, pick_code(), 1'($urandom), 1'b0, '0);
         counted++;
         while (seq_phase != PH_IDLE) begin
            if ($urandom_range(19) == 0)
               offer_word(CMD_START, 8'($urandom), 1'($urandom), 1'b0, '0);
            else begin
               if (!paused_once && seq_phase == PH_RD_SETTLE) begin
                  paused_once = 1'b1;
                  hold_requests_until_drained();
               end
               offer_word(CMD_TICK, 8'($urandom), sensor_line(), 1'b0, '0);
               counted++;
            end
         end
      end while (counted < budget);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("two_wire_sensor_measure_master_unit regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && pop && !empty) begin
         got.pins              = '{clk: rsp_clock_level, en: rsp_data_drive_enable,
                                   dat: rsp_data_level};
         got.busy_res          = rsp_busy_res;
         got.result_valid      = rsp_result_valid;
         got.measured_value    = rsp_measured_value;
         got.ack_low_error     = rsp_ack_low_error;
         got.ack_release_error = rsp_ack_release_error;
         if (expected_pin_words.size() == 0)
            report_mismatch("unexpected word", 16'h0, 16'h0);
         else
            check_word(got, expected_pin_words.pop_front());
         words_checked++;
      end
   end

   // result side; one long hold-off lets both queues fill
   initial begin
      pop = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && words_checked >= 200) begin
            hold_done = 1'b1;
            pop <= 1'b0;
            repeat (60) @(negedge clock);
            pop <= 1'b1;
         end else if (idling_on && $urandom_range(9) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clock);
         end else
            pop <= 1'b1;
      end
   end

   initial begin
      reset            = 1'b1;
      push             = 1'b0;
      req_cmd          = CMD_TICK;
      req_command_code = '0;
      req_data_line    = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_BIT_SETTLE;
      csr_wdata        = '0;
      mismatches       = 0;
      words_checked    = 0;
      idling_on        = 1'b1;
      paused_once      = 1'b0;
      hold_done        = 1'b0;
      seq_phase        = PH_IDLE;
      seq_bits         = '0;
      seq_wait         = '0;
      seq_command      = '0;
      seq_reading      = '0;
      seq_low_flag     = 1'b0;
      seq_release_flag = 1'b0;
      seq_pins         = 3'b000;
      settle_cfg       = SETTLE_RESET;
      conv_cfg         = CONV_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      apply_settings(8'd0, 16'd0);
      foreach (directed_rows[i])
         repeat (directed_rows[i].count)
            offer_word(directed_rows[i].cmd, directed_rows[i].code, directed_rows[i].line,
                       directed_rows[i].typed, directed_rows[i].want);

      apply_settings(8'd1, 16'd20);
      run_measurements(100);
      apply_settings(8'd0, 16'd0);
      run_measurements(150);
      apply_settings(8'd3, 16'd7);
      run_measurements(100);
      apply_settings(8'($urandom_range(0, 4)), 16'($urandom_range(0, 12)));
      idling_on = 1'b0;
      run_measurements(80);

      hold_requests_until_drained();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && expected_pin_words.size() == 0)
         $display("two_wire_sensor_measure_master_unit regression: pass");
      else
         $display("two_wire_sensor_measure_master_unit regression: fail");
      $finish;
   end

endmodule
